FILE: design/pscr_pkg.sv
// Package for the pseudo start code remover: byte codes, result group type,
// and the bit-realignment helpers used by the front part.
// No dependencies.
`default_nettype none

package pscr_pkg;

    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;
    localparam logic [7:0] BYTE_EPB      = 8'h02;
    localparam logic [7:0] ID_SEQ_HEADER = 8'hB0;
    localparam logic [7:0] ID_USER_DATA  = 8'hB5;
    localparam logic [7:0] ID_EXTENSION  = 8'hB1;

    localparam logic [1:0] ZRUN_MAX      = 2'd3;
    localparam logic [1:0] ZRUN_PREFIX   = 2'd2;

    localparam logic [2:0] HOLD_NONE     = 3'd0;
    localparam logic [2:0] HOLD_TWO      = 3'd2;
    localparam logic [2:0] HOLD_FOUR     = 3'd4;
    localparam logic [2:0] HOLD_SIX      = 3'd6;

    localparam logic [1:0] GRP_EMPTY     = 2'd0;
    localparam logic [1:0] GRP_ONE       = 2'd1;
    localparam logic [1:0] GRP_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] first;
        logic [7:0] second;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group grp;
    } t_head;

    // held high bits followed by the top bits of the new byte
    function automatic logic [7:0] merge_held(input logic [7:0] held, input logic [7:0] b,
                                              input logic [2:0] k);
        logic [7:0] res;
        case (k)
            HOLD_TWO:  res = {held[7:6], b[7:2]};
            HOLD_FOUR: res = {held[7:4], b[7:4]};
            HOLD_SIX:  res = {held[7:2], b[7:6]};
            default:   res = b;
        endcase
        return res;
    endfunction

    // low bits of the byte that carry over, same hold width
    function automatic logic [7:0] carry_tail(input logic [7:0] b, input logic [2:0] k);
        logic [7:0] res;
        case (k)
            HOLD_TWO:  res = {b[1:0], 6'd0};
            HOLD_FOUR: res = {b[3:0], 4'd0};
            HOLD_SIX:  res = {b[5:0], 2'd0};
            default:   res = 8'd0;
        endcase
        return res;
    endfunction

    // low bits that carry over after a stripped byte, hold width shrinks by two
    function automatic logic [7:0] strip_tail(input logic [7:0] b, input logic [2:0] k);
        logic [7:0] res;
        case (k)
            HOLD_FOUR: res = {b[3:2], 6'd0};
            HOLD_SIX:  res = {b[5:2], 4'd0};
            default:   res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/pscr_front.sv
// Front part: accepts stream bytes, tracks start codes and the realignment
// state, and builds a group of up to two result bytes per input.
// Depends on pscr_pkg.
`default_nettype none

module pscr_front
    import pscr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    input  wire logic       i_full,
    output logic            o_ready,
    output logic            o_push,
    output t_group          o_grp
);

    logic [1:0] r_zero_run, n_zero_run;
    logic       r_prefix,   n_prefix;
    logic       r_strip,    n_strip;
    logic [2:0] r_hold_cnt, n_hold_cnt;
    logic [7:0] r_held,     n_held;

    logic       w_accept;
    logic       w_wide6;
    logic [2:0] w_k;
    t_group     w_grp;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_comb begin
        n_zero_run = r_zero_run;
        n_prefix   = r_prefix;
        n_strip    = r_strip;
        n_hold_cnt = r_hold_cnt;
        n_held     = r_held;
        w_wide6    = 1'b0;
        w_grp      = '{cnt: GRP_EMPTY, first: 8'd0, second: 8'd0};

        case (i_data)
            BYTE_ZERO: begin
                if (r_prefix) begin
                    n_strip  = 1'b1;
                    n_prefix = 1'b0;
                end
                if (r_zero_run != ZRUN_MAX) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end
            BYTE_ONE: begin
                if (r_zero_run >= ZRUN_PREFIX) begin
                    n_prefix = 1'b1;
                    if (r_hold_cnt != HOLD_NONE) begin
                        n_hold_cnt   = HOLD_NONE;
                        w_grp.first  = 8'd0;
                        w_grp.cnt    = GRP_ONE;
                    end
                end
                n_zero_run = 2'd0;
            end
            BYTE_EPB: begin
                w_wide6    = r_strip && (r_zero_run == ZRUN_PREFIX);
                n_zero_run = 2'd0;
            end
            default: begin
                if (r_prefix) begin
                    n_strip  = !(i_data == ID_SEQ_HEADER || i_data == ID_USER_DATA ||
                                 i_data == ID_EXTENSION);
                    n_prefix = 1'b0;
                end
                n_zero_run = 2'd0;
            end
        endcase

        w_k = n_hold_cnt;
        if (!w_wide6) begin
            if (w_k == HOLD_NONE) begin
                if (w_grp.cnt == GRP_EMPTY) w_grp.first = i_data;
                else                        w_grp.second = i_data;
                w_grp.cnt = w_grp.cnt + 2'd1;
            end else begin
                if (w_grp.cnt == GRP_EMPTY) w_grp.first = merge_held(r_held, i_data, w_k);
                else                        w_grp.second = merge_held(r_held, i_data, w_k);
                w_grp.cnt = w_grp.cnt + 2'd1;
                n_held    = carry_tail(i_data, w_k);
            end
        end else begin
            if (w_k == HOLD_NONE) begin
                n_held     = i_data;
                n_hold_cnt = HOLD_SIX;
            end else begin
                if (w_grp.cnt == GRP_EMPTY) w_grp.first = merge_held(r_held, i_data, w_k);
                else                        w_grp.second = merge_held(r_held, i_data, w_k);
                w_grp.cnt  = w_grp.cnt + 2'd1;
                n_held     = strip_tail(i_data, w_k);
                n_hold_cnt = w_k - 3'd2;
            end
        end

        if (i_last) begin
            if (n_hold_cnt != HOLD_NONE && n_held != 8'd0 && w_grp.cnt != GRP_FULL) begin
                if (w_grp.cnt == GRP_EMPTY) w_grp.first = n_held;
                else                        w_grp.second = n_held;
                w_grp.cnt = w_grp.cnt + 2'd1;
            end
            n_zero_run = 2'd0;
            n_prefix   = 1'b0;
            n_strip    = 1'b0;
            n_hold_cnt = HOLD_NONE;
            n_held     = 8'd0;
        end
    end

    assign o_push = w_accept && (w_grp.cnt != GRP_EMPTY);
    assign o_grp  = w_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_prefix   <= 1'b0;
            r_strip    <= 1'b0;
            r_hold_cnt <= HOLD_NONE;
            r_held     <= 8'd0;
        end else if (w_accept) begin
            r_zero_run <= n_zero_run;
            r_prefix   <= n_prefix;
            r_strip    <= n_strip;
            r_hold_cnt <= n_hold_cnt;
            r_held     <= n_held;
        end
    end

endmodule

`default_nettype wire

FILE: design/pscr_queue.sv
// Two-entry shift queue of result groups between the front and back parts.
// Depends on pscr_pkg.
`default_nettype none

module pscr_queue
    import pscr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_grp,
    input  wire logic   i_pop,
    output logic        o_full,
    output t_head       o_head
);

    logic [1:0] r_fill, n_fill;
    t_group     r_slot [2];
    logic [1:0] w_base;
    logic       w_wr_idx;

    assign o_full      = (r_fill == 2'd2);
    assign o_head.valid = (r_fill != 2'd0);
    assign o_head.grp   = r_slot[0];

    assign w_base   = r_fill - {1'b0, i_pop};
    assign w_wr_idx = w_base[0];
    assign n_fill   = w_base + {1'b0, i_push};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !w_wr_idx) begin
            r_slot[0] <= i_grp;
        end else if (i_pop) begin
            r_slot[0] <= r_slot[1];
        end
        if (i_push && w_wr_idx) begin
            r_slot[1] <= i_grp;
        end
    end

endmodule

`default_nettype wire

FILE: design/pscr_back.sv
// Back part: serializes queued result groups onto the output stream through
// a registered output stage. Depends on pscr_pkg.
`default_nettype none

module pscr_back
    import pscr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_head      i_head,
    input  wire logic       i_ready,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_data,
    output logic            o_last
);

    logic       r_valid, n_valid;
    logic [7:0] r_data,  n_data;
    logic       r_last,  n_last;
    logic       r_idx,   n_idx;
    logic       w_load;

    assign w_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = i_head.valid;
            if (i_head.valid) begin
                n_data = r_idx ? i_head.grp.second : i_head.grp.first;
                n_last = r_idx || (i_head.grp.cnt == GRP_ONE);
                o_pop  = n_last;
                n_idx  = !n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

`default_nettype wire

FILE: design/pseudo_start_code_remover_unit.sv
// Top level of the pseudo start code remover: front, queue and back parts.
// Depends on pscr_pkg, pscr_front, pscr_queue, pscr_back.
//
// Usage:
//   Input stream s_axis_*: one raw byte per transaction in tdata, tlast marks
//   the final byte of a unit and flushes held bits before the state clears.
//   Output stream m_axis_*: one cleaned byte per transaction; tlast is set on
//   the last result byte caused by an input byte. An input may cause zero,
//   one or two output bytes.
//   Path: each result byte passes through the group queue and then the
//   output register before it appears on m_axis.
//   Throughput: one input byte per cycle while m_axis_tready is high and each
//   input yields at most one result; two results of one input leave one at
//   a time via the single-byte output register and the two-entry group queue.
//   Reset (synchronous, active low) clears the start code state, the held
//   bits, the queue and the output register.
//   When the receiver stalls, the output holds, the queue fills and
//   s_axis_tready drops once both queue entries are taken.
`default_nettype none

module pseudo_start_code_remover_unit
    import pscr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast
);

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    t_group w_grp;
    t_head  w_head;

    pscr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_grp   (w_grp)
    );

    pscr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_grp),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    pscr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_ready (m_axis_tready),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: design/pscr_checker.sv
// Port-level checker for pseudo_start_code_remover_unit, bound to the top.
// Depends on pseudo_start_code_remover_unit ports only.
`default_nettype none

module pscr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("waiting input changed");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid ##1 !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output idle");

endmodule

bind pseudo_start_code_remover_unit pscr_checker u_pscr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
